// File: hw/rtl/soct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package soct_pkg;

  localparam int CHAR_W  = 8;
  localparam int TALLY_W = 32;
  localparam int OP_W    = 2;

  localparam logic [OP_W-1:0] OP_PATTERN = 2'd0;
  localparam logic [OP_W-1:0] OP_SOURCE  = 2'd1;
  localparam logic [OP_W-1:0] OP_END     = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] ch;
  } soct_in_t;

  typedef struct packed {
    logic [TALLY_W-1:0] tally;
    logic               pattern_overflow;
  } soct_out_t;

  typedef struct packed {
    logic clear;
    logic src_step;
    logic pat_step;
  } soct_cell_ctl_t;

  typedef struct packed {
    logic [CHAR_W-1:0] hist;
    logic              hist_vld;
    logic [CHAR_W-1:0] pat;
    logic              pat_act;
  } soct_link_t;

endpackage

`default_nettype wire

// File: hw/rtl/soct_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module soct_cell
  import soct_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire soct_cell_ctl_t    ctl,
  input  wire logic [CHAR_W-1:0] src_char,
  input  wire soct_link_t        link_in,
  output soct_link_t             link_out,
  output logic                   ok,
  output logic                   hit
);

  logic [CHAR_W-1:0] hist_r;
  logic              hvld_r;
  logic [CHAR_W-1:0] pat_r;
  logic              act_r;
  logic              pat_eq_hist;
  logic              pat_eq_src;

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      hvld_r <= 1'b0;
      act_r  <= 1'b0;
    end else begin
      if (ctl.src_step) begin
        hvld_r <= link_in.hist_vld;
      end
      if (ctl.pat_step) begin
        act_r <= link_in.pat_act;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.src_step) begin
      hist_r <= link_in.hist;
    end
    if (ctl.pat_step) begin
      pat_r <= link_in.pat;
    end
  end

  assign pat_eq_hist = (pat_r == hist_r);
  assign pat_eq_src  = (pat_r == src_char);

  // Inactive cells lie beyond the pattern and never block a match.
  assign ok  = !act_r || (hvld_r && pat_eq_hist);
  assign hit = act_r && pat_eq_src;

  assign link_out.hist     = hist_r;
  assign link_out.hist_vld = hvld_r;
  assign link_out.pat      = pat_r;
  assign link_out.pat_act  = act_r;

endmodule

`default_nettype wire

// File: hw/rtl/soct_out_buf.sv
`timescale 1ns / 1ps
`default_nettype none

module soct_out_buf
  import soct_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire soct_out_t push_data,
  output logic           space,
  output logic           out_valid,
  input  wire logic      out_ready,
  output soct_out_t      out_data
);

  logic      out_vld_r;
  logic      out_vld_nxt;
  soct_out_t out_r;
  soct_out_t out_nxt;
  logic      skid_vld_r;
  logic      skid_vld_nxt;
  soct_out_t skid_r;
  soct_out_t skid_nxt;
  logic      take;

  assign take = out_vld_r && out_ready;

  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_nxt      = out_r;
    skid_vld_nxt = skid_vld_r;
    skid_nxt     = skid_r;
    if (take) begin
      if (skid_vld_r) begin
        out_nxt      = skid_r;
        skid_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt = 1'b0;
      end
    end
    if (push) begin
      if (!out_vld_r || take) begin
        out_nxt     = push_data;
        out_vld_nxt = 1'b1;
      end else begin
        skid_nxt     = push_data;
        skid_vld_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign space     = !skid_vld_r;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// File: hw/rtl/substring_or_charset_tally_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Streaming tally of a pattern within a source string.
// Each input transaction carries an op and a character: append a pattern
// character, take a source character, or end the source. Only an end
// transaction yields a result transaction, holding the tally and the pattern
// overflow flag; the end also clears the pattern, history and tally.
// cfg_we writes the mode bit: 0 counts non-overlapping whole-pattern
// matches, 1 counts source characters found in the pattern set.
// The mode bit is kept across end transactions and is cleared only by reset.
// One input transaction is accepted per cycle while in_ready is high.
// The newest pattern character sits in a register and each earlier one in
// a cell; together they hold the reversed pattern and the source history
// and compare them all in the cycle a source character arrives. The end
// result is registered in a two-entry output buffer that lets input go on
// while one result waits; in_ready drops only when two results are held.
// Reset (synchronous, active low) clears all flags, counts and the mode bit.

module substring_or_charset_tally_unit
  import soct_pkg::*;
#(
  parameter int MAX_PATTERN = 16,
  parameter int COUNT_BITS  = 32
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire soct_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output soct_out_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic      cfg_wdata
);

  localparam int NCELL = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
  localparam int CNT_W = $clog2(MAX_PATTERN + 1);

  logic                  set_mode_r;
  logic [CHAR_W-1:0]     last_r;
  logic                  last_vld_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [CNT_W-1:0]      cool_r;
  logic                  ovf_r;
  logic [COUNT_BITS-1:0] tally_r;

  logic                  acc;
  logic                  is_pat;
  logic                  is_src;
  logic                  is_end;
  logic                  room;
  logic [CHAR_W-1:0]     c;
  soct_cell_ctl_t        ctl;
  soct_link_t            links [0:NCELL];
  logic [NCELL-1:0]      ok_vec;
  logic [NCELL-1:0]      hit_vec;
  logic                  last_eq;
  logic                  window_match;
  logic                  set_hit;
  logic                  bump;
  logic [COUNT_BITS-1:0] tally_nxt;
  logic [CNT_W-1:0]      cool_nxt;
  logic [63:0]           tally_ext;
  soct_out_t             result;
  logic                  space;

  assign c      = in_data.ch;
  assign acc    = in_valid && in_ready;
  assign is_pat = acc && (in_data.op == OP_PATTERN);
  assign is_src = acc && (in_data.op == OP_SOURCE);
  assign is_end = acc && (in_data.op == OP_END);
  assign room   = (cnt_r < CNT_W'(MAX_PATTERN));

  assign ctl.clear    = is_end;
  assign ctl.src_step = is_src;
  assign ctl.pat_step = is_pat && room;

  assign links[0].hist     = c;
  assign links[0].hist_vld = 1'b1;
  assign links[0].pat      = last_r;
  assign links[0].pat_act  = last_vld_r;

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    soct_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .src_char (c),
      .link_in  (links[k]),
      .link_out (links[k+1]),
      .ok       (ok_vec[k]),
      .hit      (hit_vec[k])
    );
  end

  assign last_eq      = last_vld_r && (last_r == c);
  assign window_match = last_eq && (&ok_vec);
  assign set_hit      = last_eq || (|hit_vec);

  always_comb begin
    bump     = 1'b0;
    cool_nxt = cool_r;
    if (set_mode_r) begin
      bump = set_hit;
    end else if (cool_r != '0) begin
      cool_nxt = cool_r - CNT_W'(1);
    end else if (window_match) begin
      bump     = 1'b1;
      cool_nxt = cnt_r - CNT_W'(1);
    end
  end

  assign tally_nxt = (bump && (tally_r != '1)) ? tally_r + COUNT_BITS'(1) : tally_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_mode_r <= 1'b0;
    end else if (cfg_we) begin
      set_mode_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || is_end) begin
      last_vld_r <= 1'b0;
      cnt_r      <= '0;
      cool_r     <= '0;
      ovf_r      <= 1'b0;
      tally_r    <= '0;
    end else begin
      if (is_pat) begin
        if (room) begin
          last_vld_r <= 1'b1;
          cnt_r      <= cnt_r + CNT_W'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (is_src) begin
        cool_r  <= cool_nxt;
        tally_r <= tally_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_pat && room) begin
      last_r <= c;
    end
  end

  assign tally_ext               = 64'(tally_r);
  assign result.tally            = tally_ext[TALLY_W-1:0];
  assign result.pattern_overflow = ovf_r;

  soct_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (is_end),
    .push_data (result),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign in_ready = space;

endmodule

`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import soct_pkg::*;

  localparam int PAT_DEPTH = 16;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam longint unsigned TALLY_MAX = 64'h0000_0000_FFFF_FFFF;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 4;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  soct_in_t in_data;
  logic out_valid;
  logic out_ready;
  soct_out_t out_data;
  logic cfg_we;
  logic cfg_wdata;

  substring_or_charset_tally_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  logic [CHAR_W-1:0] pat_chars [PAT_DEPTH];
  logic [CHAR_W-1:0] src_hist [PAT_DEPTH];
  int unsigned pat_len;
  int unsigned src_seen;
  int unsigned skip_left;
  bit pat_too_long;
  bit set_mode_q;
  longint unsigned tally_acc;
  soct_out_t expected_tallies [$];

  logic [CHAR_W-1:0] alphabet [3];
  int unsigned alphabet_n;
  bit alphabet_wide;

  bit steady;
  int errors;
  int items_sent;
  int results_checked;
  int nonzero_tallies;
  int overflow_results;
  int streams_run;
  int mode_writes;
  int stall_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void clear_tracker();
    for (int k = 0; k < PAT_DEPTH; k++) begin
      pat_chars[k] = '0;
      src_hist[k] = '0;
    end
    pat_len = 0;
    src_seen = 0;
    skip_left = 0;
    pat_too_long = 1'b0;
    tally_acc = 0;
  endfunction

  function automatic bit window_hit(logic [CHAR_W-1:0] c);
    int unsigned n;
    n = pat_len;
    if (n == 0 || src_seen < n - 1) return 1'b0;
    if (pat_chars[n-1] != c) return 1'b0;
    for (int j = 0; j + 1 < n; j++) begin
      if (pat_chars[n-2-j] != src_hist[j]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit in_pattern_set(logic [CHAR_W-1:0] c);
    for (int k = 0; k < pat_len; k++) begin
      if (pat_chars[k] == c) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void bump_tally();
    if (tally_acc < TALLY_MAX) tally_acc++;
  endfunction

  function automatic void track_item(soct_in_t it);
    soct_out_t res;
    case (it.op)
      OP_PATTERN: begin
        if (pat_len < PAT_DEPTH) begin
          pat_chars[pat_len] = it.ch;
          pat_len++;
        end else begin
          pat_too_long = 1'b1;
        end
      end
      OP_SOURCE: begin
        if (set_mode_q) begin
          if (in_pattern_set(it.ch)) bump_tally();
        end else if (skip_left > 0) begin
          skip_left--;
        end else if (window_hit(it.ch)) begin
          bump_tally();
          skip_left = pat_len - 1;
        end
        for (int j = PAT_DEPTH - 1; j > 0; j--) src_hist[j] = src_hist[j-1];
        src_hist[0] = it.ch;
        if (src_seen < PAT_DEPTH) src_seen++;
      end
      OP_END: begin
        res.tally = tally_acc[TALLY_W-1:0];
        res.pattern_overflow = pat_too_long;
        expected_tallies.push_back(res);
        clear_tracker();
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] next_char();
    if (alphabet_wide) return CHAR_W'($urandom_range(255));
    return alphabet[$urandom_range(alphabet_n - 1)];
  endfunction

  task automatic send_item(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch);
    soct_in_t it;
    it.op = op;
    it.ch = ch;
    while (!steady && $urandom_range(99) < 20) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    track_item(it);
    if (op != OP_UNUSED) items_sent++;
  endtask

  task automatic write_mode(bit mode);
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_tallies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    set_mode_q = mode;
    mode_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_stream(bit switching);
    int unsigned plen;
    int unsigned slen;
    int unsigned roll;
    foreach (alphabet[k]) alphabet[k] = CHAR_W'($urandom_range(255));
    alphabet_n = $urandom_range(3, 2);
    alphabet_wide = ($urandom_range(9) == 0);
    roll = $urandom_range(99);
    if (roll < 5) plen = 0;
    else if (roll < 70) plen = $urandom_range(4, 1);
    else if (roll < 88) plen = $urandom_range(PAT_DEPTH, 5);
    else plen = $urandom_range(PAT_DEPTH + 4, PAT_DEPTH + 1);
    slen = ($urandom_range(19) == 0) ? 0 : $urandom_range(48, 1);
    repeat (plen) send_item(OP_PATTERN, next_char());
    for (int s = 0; s < slen; s++) begin
      roll = $urandom_range(99);
      if (roll < 3) send_item(OP_UNUSED, CHAR_W'($urandom_range(255)));
      else if (roll < 6) send_item(OP_PATTERN, next_char());
      else if (switching && roll < 9) write_mode(!set_mode_q);
      send_item(OP_SOURCE, next_char());
    end
    send_item(OP_END, CHAR_W'($urandom_range(255)));
    streams_run++;
  endtask

  task automatic run_streams(int target, bit switching);
    int first;
    first = items_sent;
    while (items_sent - first < target) run_stream(switching);
  endtask

  task automatic test_empty_inputs();
    send_item(OP_END, 8'h00);
    send_item(OP_PATTERN, "x");
    send_item(OP_END, 8'hFF);
  endtask

  task automatic test_unused_op();
    send_item(OP_UNUSED, 8'hFF);
    send_item(OP_UNUSED, 8'h00);
  endtask

  task automatic test_non_overlap();
    send_item(OP_PATTERN, "a");
    send_item(OP_PATTERN, "a");
    repeat (5) send_item(OP_SOURCE, "a");
    send_item(OP_END, 8'h00);
  endtask

  task automatic test_late_pattern();
    send_item(OP_PATTERN, 8'hFF);
    send_item(OP_SOURCE, 8'hFF);
    send_item(OP_PATTERN, 8'h00);
    send_item(OP_SOURCE, 8'hFF);
    send_item(OP_SOURCE, 8'h00);
    send_item(OP_END, 8'h00);
  endtask

  task automatic test_mode_change_midstream();
    write_mode(1'b1);
    send_item(OP_PATTERN, "a");
    send_item(OP_PATTERN, "b");
    send_item(OP_SOURCE, "a");
    send_item(OP_SOURCE, "c");
    write_mode(1'b0);
    send_item(OP_SOURCE, "b");
    send_item(OP_END, 8'h00);
  endtask

  task automatic test_random_substring_steady();
    steady = 1'b1;
    run_streams(400, 1'b0);
    steady = 1'b0;
  endtask

  task automatic test_random_substring();
    run_streams(450, 1'b0);
  endtask

  task automatic test_random_charset();
    write_mode(1'b1);
    run_streams(450, 1'b0);
  endtask

  task automatic test_random_mode_switching();
    run_streams(350, 1'b1);
    write_mode(1'b0);
  endtask

  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 20);
  end

  always @(posedge clk) begin
    soct_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_tallies.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual tally %0d overflow %0b",
                 $time, out_data.tally, out_data.pattern_overflow);
        errors++;
      end else begin
        want = expected_tallies.pop_front();
        results_checked++;
        if (want.tally != 0) nonzero_tallies++;
        if (want.pattern_overflow) overflow_results++;
        if (out_data.tally !== want.tally) begin
          $display("%0t: tally mismatch, expected %0d, actual %0d",
                   $time, want.tally, out_data.tally);
          errors++;
        end
        if (out_data.pattern_overflow !== want.pattern_overflow) begin
          $display("%0t: pattern_overflow mismatch, expected %0b, actual %0b",
                   $time, want.pattern_overflow, out_data.pattern_overflow);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    steady = 1'b0;
    errors = 0;
    items_sent = 0;
    results_checked = 0;
    nonzero_tallies = 0;
    overflow_results = 0;
    streams_run = 0;
    mode_writes = 0;
    stall_cycles = 0;
    set_mode_q = 1'b0;
    clear_tracker();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_inputs();
    test_unused_op();
    test_non_overlap();
    test_late_pattern();
    test_mode_change_midstream();
    test_random_substring_steady();
    test_random_substring();
    test_random_charset();
    test_random_mode_switching();

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_tallies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d input transactions in %0d random streams, wrote the mode %0d times.",
             items_sent, streams_run, mode_writes);
    $display("Checked %0d tallies: %0d nonzero, %0d with pattern overflow, %0d errors.",
             results_checked, nonzero_tallies, overflow_results, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
